/* sv/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define TEB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");

// property checked on every rising edge, reset included
`define TEB_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

/* sv/teb_pkg.sv */
// ----------------------------------------------------------------------------
// teb_pkg
// types, constants and the arctangent table of the emergency brake unit
// ----------------------------------------------------------------------------
`default_nettype none
package teb_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int NSTG = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
   localparam int XW = 28;
   localparam int ZW = 26;
   localparam int QW = 16;
   localparam logic [14:0] INV_GAIN_Q16 = 15'd24167;
   localparam logic [14:0] ONE_Q14 = 15'd16384;

   typedef enum logic [1:0] {
      CSR_WARN_DIST  = 2'd0,
      CSR_EMERG_DIST = 2'd1,
      CSR_MAX_DECEL  = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic               front_valid;
      logic signed [23:0] front_x;
      logic signed [23:0] front_y;
      logic signed [15:0] front_speed;
      logic signed [23:0] ego_x;
      logic signed [23:0] ego_y;
      logic        [15:0] ego_heading;
      logic signed [15:0] ego_speed;
   } req_type;

   typedef struct packed {
      logic signed [15:0] new_speed;
      logic               brake_applied;
      logic        [23:0] range_out;
      logic        [15:0] ttc_out;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic                 fv;
      logic signed [15:0]   ego_v;
      logic signed [16:0]   rel;
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic        [23:0]   range;
      logic                 sat;
      logic                 emerg;
      logic                 warn;
      logic        [15:0]   r1;
      logic        [15:0]   d1;
      logic        [15:0]   n1;
      logic        [17:0]   r2;
      logic        [17:0]   d2;
      logic        [15:0]   n2;
   } tok_type;

   // arctangent of 2^-i in units of 2^-24 turn
   function automatic logic [21:0] atan_turn24(input logic [4:0] i);
      logic [21:0] a;
      case (i)
         5'd0:  a = 22'd2097152;
         5'd1:  a = 22'd1238021;
         5'd2:  a = 22'd654136;
         5'd3:  a = 22'd332050;
         5'd4:  a = 22'd166669;
         5'd5:  a = 22'd83416;
         5'd6:  a = 22'd41718;
         5'd7:  a = 22'd20860;
         5'd8:  a = 22'd10430;
         5'd9:  a = 22'd5215;
         5'd10: a = 22'd2608;
         5'd11: a = 22'd1304;
         5'd12: a = 22'd652;
         5'd13: a = 22'd326;
         5'd14: a = 22'd163;
         5'd15: a = 22'd81;
         5'd16: a = 22'd41;
         5'd17: a = 22'd20;
         5'd18: a = 22'd10;
         5'd19: a = 22'd5;
         5'd20: a = 22'd3;
         5'd21: a = 22'd1;
         5'd22: a = 22'd1;
         default: a = 22'd0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

/* sv/teb_cordic_cell.sv */
// ----------------------------------------------------------------------------
// teb_cordic_cell
// one registered cordic micro-rotation, rotation or vectoring mode
// ----------------------------------------------------------------------------
`default_nettype none
module teb_cordic_cell
   import teb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       adv,
   input  wire logic       vec_mode,
   input  wire logic [4:0] stage,
   input  wire tok_type    tok_i,
   output tok_type         tok_o
);

   tok_type tok_ff;
   tok_type tok_in;
   logic signed [XW-1:0] xsh;
   logic signed [XW-1:0] ysh;
   logic signed [ZW-1:0] ang;
   logic up;

   always_comb begin
      xsh = tok_i.x >>> stage;
      ysh = tok_i.y >>> stage;
      ang = $signed(ZW'(atan_turn24(stage)));
      // rotation follows the residual angle, vectoring drives y to zero
      up = vec_mode ? tok_i.y[XW-1] : !tok_i.z[ZW-1];
      tok_in = tok_i;
      if (up) begin
         tok_in.x = tok_i.x - ysh;
         tok_in.y = tok_i.y + xsh;
         tok_in.z = tok_i.z - ang;
      end else begin
         tok_in.x = tok_i.x + ysh;
         tok_in.y = tok_i.y - xsh;
         tok_in.z = tok_i.z + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (adv) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule
`default_nettype wire

/* sv/teb_div_cell.sv */
// ----------------------------------------------------------------------------
// teb_div_cell
// one restoring division step for the ttc and the decel factor quotients
// ----------------------------------------------------------------------------
`default_nettype none
module teb_div_cell
   import teb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    adv,
   input  wire tok_type tok_i,
   output tok_type      tok_o
);

   tok_type tok_ff;
   tok_type tok_in;
   logic [16:0] t1;
   logic [18:0] t2;
   logic q1;
   logic q2;

   always_comb begin
      t1 = {tok_i.r1, tok_i.n1[15]};
      t2 = {tok_i.r2, tok_i.n2[15]};
      q1 = t1 >= {1'b0, tok_i.d1};
      q2 = t2 >= {1'b0, tok_i.d2};
      tok_in = tok_i;
      // quotient bits shift in where the dividend bits leave
      tok_in.r1 = q1 ? 16'(t1 - {1'b0, tok_i.d1}) : t1[15:0];
      tok_in.r2 = q2 ? 18'(t2 - {1'b0, tok_i.d2}) : t2[17:0];
      tok_in.n1 = {tok_i.n1[14:0], q1};
      tok_in.n2 = {tok_i.n2[14:0], q2};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (adv) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule
`default_nettype wire

/* sv/ttc_emergency_brake_unit.sv */
// ----------------------------------------------------------------------------
// ttc_emergency_brake_unit
// time-to-collision emergency braking for one front object per word
// ----------------------------------------------------------------------------
// A new word is taken every cycle while the chain advances; a result passes the input
// register, the chain of cordic rotation and vectoring cells, the gain and setup
// registers, sixteen divider cells and the output register. The whole chain moves as one and
// halts only while a finished result is stalled at the output.
`default_nettype none
module ttc_emergency_brake_unit
   import teb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   logic [15:0] warn_dist_ff;
   logic [15:0] emerg_dist_ff;
   logic [15:0] max_decel_ff;
   logic adv;

   tok_type rot_t [NSTG+1];
   tok_type vec_t [NSTG+1];
   tok_type div_t [QW+1];
   tok_type front_in;
   tok_type gain_in;
   tok_type gain_ff;
   tok_type setup_in;
   tok_type setup_ff;
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic rsp_valid_ff;

   logic signed [24:0] dx;
   logic signed [24:0] dy;
   logic [15:0] th;
   logic flip;
   logic [XW-2:0] xpos;
   logic [XW+14:0] prod_g;
   logic [15:0] relu;
   logic [17:0] den;
   logic closing;
   logic [17:0] diff;
   logic [33:0] num2;
   logic [14:0] fq;
   logic [29:0] prod_s;
   logic [15:0] scaled;
   logic dclosing;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         warn_dist_ff  <= 16'd7680;
         emerg_dist_ff <= 16'd2560;
         max_decel_ff  <= 16'd11469;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WARN_DIST:  warn_dist_ff  <= csr_wdata;
            CSR_EMERG_DIST: emerg_dist_ff <= csr_wdata;
            CSR_MAX_DECEL:  max_decel_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // offset and quadrant fold into [-1/4, 1/4) turn
   always_comb begin
      dx = 25'(req_data.front_x) - 25'(req_data.ego_x);
      dy = 25'(req_data.front_y) - 25'(req_data.ego_y);
      th = 16'(17'h10000 - {1'b0, req_data.ego_heading});
      flip = th[15] ^ th[14];
      front_in = '0;
      front_in.valid = req_valid;
      front_in.fv = req_data.front_valid;
      front_in.ego_v = req_data.ego_speed;
      front_in.rel = 17'(req_data.ego_speed) - 17'(req_data.front_speed);
      front_in.x = flip ? -XW'(dx) : XW'(dx);
      front_in.y = flip ? -XW'(dy) : XW'(dy);
      if (flip) begin
         th = th ^ 16'h8000;
      end
      front_in.z = $signed({{(ZW-24){th[15]}}, th, 8'h00});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_t[0].valid <= 1'b0;
      end else if (adv) begin
         rot_t[0] <= front_in;
      end
   end

   for (genvar i = 0; i < NSTG; i++) begin : g_rot
      teb_cordic_cell u_cell (
         .clock(clock), .reset(reset), .adv(adv), .vec_mode(1'b0),
         .stage(5'(i)), .tok_i(rot_t[i]), .tok_o(rot_t[i+1])
      );
   end

   always_comb begin
      vec_t[0] = rot_t[NSTG];
      if (rot_t[NSTG].x[XW-1]) begin
         vec_t[0].x = -rot_t[NSTG].x;
         vec_t[0].y = -rot_t[NSTG].y;
      end
   end

   for (genvar i = 0; i < NSTG; i++) begin : g_vec
      teb_cordic_cell u_cell (
         .clock(clock), .reset(reset), .adv(adv), .vec_mode(1'b1),
         .stage(5'(i)), .tok_i(vec_t[i]), .tok_o(vec_t[i+1])
      );
   end

   // gain compensation and range saturation
   always_comb begin
      gain_in = vec_t[NSTG];
      xpos = vec_t[NSTG].x[XW-1] ? '0 : vec_t[NSTG].x[XW-2:0];
      prod_g = (XW+15)'(xpos) * (XW+15)'(INV_GAIN_Q16) + (XW+15)'(32768);
      gain_in.range = (prod_g[XW+14:16] > (XW-1)'(24'hFFFFFF)) ? 24'hFFFFFF
                      : prod_g[39:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff.valid <= 1'b0;
      end else if (adv) begin
         gain_ff <= gain_in;
      end
   end

   // band tests and divider operands
   always_comb begin
      setup_in = gain_ff;
      relu = gain_ff.rel[15:0];
      closing = gain_ff.fv && !gain_ff.rel[16] && (gain_ff.rel != '0);
      den = {2'b00, relu} + {1'b0, relu, 1'b0};
      setup_in.emerg = closing && (gain_ff.range <= 24'(relu))
                       && (gain_ff.range <= 24'(emerg_dist_ff));
      setup_in.warn = closing && !setup_in.emerg && (gain_ff.range <= 24'(den))
                      && (gain_ff.range <= 24'(warn_dist_ff));
      setup_in.sat = gain_ff.range >= {relu, 8'h00};
      diff = den - gain_ff.range[17:0];
      num2 = 34'(max_decel_ff) * 34'(diff);
      setup_in.d1 = closing ? relu : 16'd1;
      setup_in.r1 = closing ? gain_ff.range[23:8] : 16'd0;
      setup_in.n1 = closing ? {gain_ff.range[7:0], 8'h00} : 16'd0;
      setup_in.d2 = setup_in.warn ? den : 18'd1;
      setup_in.r2 = setup_in.warn ? num2[33:16] : 18'd0;
      setup_in.n2 = setup_in.warn ? num2[15:0] : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ff.valid <= 1'b0;
      end else if (adv) begin
         setup_ff <= setup_in;
      end
   end

   assign div_t[0] = setup_ff;

   for (genvar i = 0; i < QW; i++) begin : g_div
      teb_div_cell u_cell (
         .clock(clock), .reset(reset), .adv(adv),
         .tok_i(div_t[i]), .tok_o(div_t[i+1])
      );
   end

   // final speed decision
   always_comb begin
      dclosing = div_t[QW].fv && !div_t[QW].rel[16] && (div_t[QW].rel != '0);
      fq = (div_t[QW].n2 > 16'(ONE_Q14)) ? ONE_Q14 : div_t[QW].n2[14:0];
      prod_s = 30'(div_t[QW].ego_v[14:0]) * 30'(ONE_Q14 - fq);
      scaled = 16'(prod_s[29:14]);
      rsp_in.new_speed = div_t[QW].ego_v;
      rsp_in.brake_applied = 1'b0;
      rsp_in.range_out = div_t[QW].fv ? div_t[QW].range : 24'd0;
      rsp_in.ttc_out = (dclosing && !div_t[QW].sat) ? div_t[QW].n1 : 16'hFFFF;
      if (div_t[QW].ego_v > 16'sd0) begin
         if (div_t[QW].emerg) begin
            rsp_in.new_speed = '0;
            rsp_in.brake_applied = 1'b1;
         end else if (div_t[QW].warn && ($signed(scaled) < div_t[QW].ego_v)) begin
            rsp_in.new_speed = $signed(scaled);
            rsp_in.brake_applied = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_t[QW].valid;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

/* sv/teb_checker.sv */
// ----------------------------------------------------------------------------
// teb_checker
// port level checks of the emergency brake unit
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module teb_checker
   import teb_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire req_type     req_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire rsp_type     rsp_data,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [1:0]  csr_index,
   input wire logic [15:0] csr_wdata
);

   `TEB_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)
   `TEB_ASSERT(a_stall_only_blocked, clock, reset, req_stall |-> (rsp_valid && rsp_stall))
   `TEB_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> $stable(rsp_data))
   `TEB_ASSERT(a_brake_nonneg, clock, reset, (rsp_valid && rsp_data.brake_applied) |-> !rsp_data.new_speed[15])
   `TEB_ASSERT(a_brake_ttc, clock, reset, (rsp_valid && rsp_data.brake_applied) |-> (rsp_data.ttc_out <= 16'd768))

endmodule

bind ttc_emergency_brake_unit teb_checker u_teb_checker (.*);
`default_nettype wire
